@@ hw/rtl/int_to_decimal_ascii_macros.svh @@
// Assertion macros for the int_to_decimal_ascii RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ITDA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itda check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ITDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itda check failed");
`else
`define ITDA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ITDA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/itda_pkg.sv @@
// Package for int_to_decimal_ascii: widths, character codes, FSM state and the control
// structs from the sequencer to the BCD datapath and the output register. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    // 2147483648 has ten decimal digits
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } itda_state_t;

    // sequencer -> BCD datapath
    typedef struct packed {
        logic load;     // capture magnitude, clear BCD
        logic convert;  // one double-dabble step
        logic shift;    // drop the top BCD digit
    } dab_ctrl_t;

    // sequencer -> output register
    typedef struct packed {
        logic              load;
        logic [CHAR_W-1:0] code;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

@@ hw/rtl/itda_dabble.sv @@
// Bit-serial binary-to-BCD datapath (shift-add-3) for int_to_decimal_ascii.
// Depends on itda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itda_dabble
    import itda_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [VALUE_W-1:0] value,
    input  wire dab_ctrl_t          ctrl,
    output logic [DIGIT_W-1:0]      top_digit
);

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [VALUE_W-1:0] mag_in;

    // magnitude; the most negative value wraps to 2^31, which is right unsigned
    assign mag_in = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // next values of the shift registers
    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        priority if (ctrl.load) begin
            mag_next = mag_in;
            bcd_next = '0;
        end else if (ctrl.convert) begin
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
        end else if (ctrl.shift) begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

@@ hw/rtl/itda_ctrl.sv @@
// Sequencer for int_to_decimal_ascii: conversion steps, leading-zero skip,
// sign and digit emission. Depends on itda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itda_ctrl
    import itda_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_xfer,
    input  wire logic          sign_in,
    input  wire logic          slot_free,
    input  wire logic [DIGIT_W-1:0] top_digit,
    output logic               in_ready,
    output dab_ctrl_t          dab,
    output emit_t              emit
);

    itda_state_t              state_reg, state_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                     neg_reg, neg_next;
    logic                     skip_zero;

    // a leading zero is dropped unless it is the only digit left
    assign skip_zero = (top_digit == '0) && (dig_cnt_reg != DIG_CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_CONV;
            end
            ST_CONV: begin
                if (bit_cnt_reg == '0) state_next = ST_SKIP;
            end
            ST_SKIP: begin
                if (!skip_zero) state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (slot_free) state_next = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (slot_free && dig_cnt_reg == DIG_CNT_W'(1)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        in_ready     = 1'b0;
        dab          = '0;
        emit         = '0;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    dab.load     = 1'b1;
                    neg_next     = sign_in;
                    bit_cnt_next = BIT_CNT_W'(VALUE_W - 1);
                end
            end
            ST_CONV: begin
                dab.convert  = 1'b1;
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
            end
            ST_SKIP: begin
                if (skip_zero) begin
                    dab.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            ST_SIGN: begin
                // at least one digit always follows the sign
                emit.load = slot_free;
                emit.code = ASCII_MINUS;
                emit.last = 1'b0;
            end
            ST_DIGITS: begin
                emit.load = slot_free;
                emit.code = ASCII_ZERO + CHAR_W'(top_digit);
                emit.last = (dig_cnt_reg == DIG_CNT_W'(1));
                if (slot_free) begin
                    dab.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/int_to_decimal_ascii.sv @@
// A value takes 32 shift-add-3 steps in the BCD register; leading zeros are then
// skipped and the sign and digits emitted, each character waiting for a free output slot.
// Characters leave through an output register; the next input is taken once the
// last character of the current text has been loaded there.
// Reset (aresetn, synchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
`default_nettype none
`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CHAR_W-1:0]       m_char_code,
    output logic                    m_last
);

    dab_ctrl_t           dab;
    emit_t               emit;
    logic [DIGIT_W-1:0]  top_digit;
    logic                in_xfer;
    logic                slot_free;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_code_reg;
    logic                m_last_reg;

    assign in_xfer   = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    itda_dabble u_dabble (
        .aclk      (aclk),
        .value     (s_value),
        .ctrl      (dab),
        .top_digit (top_digit)
    );

    itda_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_xfer   (in_xfer),
        .sign_in   (s_value[VALUE_W-1]),
        .slot_free (slot_free),
        .top_digit (top_digit),
        .in_ready  (s_ready),
        .dab       (dab),
        .emit      (emit)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.load) begin
            m_char_code_reg <= emit.code;
            m_last_reg      <= emit.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last      = m_last_reg;

    // checks
    `ITDA_ASSERT_IMPL(a_no_emit_on_accept, aclk, aresetn, in_xfer, !emit.load)
    `ITDA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_xfer, !s_ready)
    `ITDA_ASSERT_IMPL(a_sign_not_last, aclk, aresetn, m_valid && (m_char_code == ASCII_MINUS), !m_last)
    `ITDA_ASSERT_IMPL(a_char_legal, aclk, aresetn, m_valid, (m_char_code == ASCII_MINUS) || ((m_char_code >= ASCII_ZERO) && (m_char_code <= ASCII_NINE)))

endmodule

`default_nettype wire

@@ tb/int_to_decimal_ascii_tb.sv @@
// Self-checking testbench for int_to_decimal_ascii: directed table plus random values, each
// character transfer checked against typed text or a behavioral decimal-text predictor.
// Depends on itda_pkg and the int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module int_to_decimal_ascii_tb;
    import itda_pkg::*;

    localparam int  DIR_N       = 21;
    localparam int  RAND_N      = 350;
    localparam int  DRAIN_TAIL  = 60;
    localparam time RUN_LIMIT   = 2_000_000;

    // receiver stall modes, re-picked at random by the backpressure process
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_char_code;
    logic               m_last;

    text_char_t pending_chars[$];
    int         error_count = 0;
    int         burst_left  = 0;
    int         rx_cycle    = 0;
    rx_mode_t   rx_mode     = RX_OPEN;

    // directed stimulus; an empty text means the predictor supplies the expectation
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, 32'hC465_3601, 32'hC465_3600, 32'd100, 32'hFFFF_FF9C,
        32'd12345, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
        32'h4000_0000
    };
    string dir_text [DIR_N] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "", "", "", "", "",
        "", "", "", "", "",
        ""
    };

    int_to_decimal_ascii i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Decimal text of a two's complement value; the most negative value
    // negates to itself, which read unsigned is exactly its magnitude.
    task automatic predict_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W:0]   mag;
        logic [DIGIT_W-1:0] digit_buf [NUM_DIGITS];
        int                 ndig;
        text_char_t         ch;
        mag  = raw[VALUE_W-1] ? {1'b0, -raw} : {1'b0, raw};
        ndig = 0;
        do begin
            digit_buf[ndig] = DIGIT_W'(mag % 10);
            mag             = mag / 10;
            ndig++;
        end while (mag != 0);
        if (raw[VALUE_W-1]) begin
            ch.code = ASCII_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int d = ndig - 1; d >= 0; d--) begin
            ch.code = ASCII_ZERO + CHAR_W'(digit_buf[d]);
            ch.last = (d == 0);
            pending_chars.push_back(ch);
        end
    endtask

    task automatic push_typed_text(input string text);
        text_char_t ch;
        for (int i = 0; i < text.len(); i++) begin
            ch.code = text[i];
            ch.last = (i == text.len() - 1);
            pending_chars.push_back(ch);
        end
    endtask

    // Random value drawn from full-range, small, decade-edge, extreme and shifted classes, often negated.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 99);
            6: begin
                k = $urandom_range(0, 9);
                p = 1;
                for (int i = 0; i < k; i++) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            7:          v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                 : 32'h7FFF_FFFF - $urandom_range(0, 3);
            8:          v = $urandom_range(0, 99999);
            default:    v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) && v[VALUE_W-1] == 1'b0) v = -v;
        return v;
    endfunction

    // Present one value; bursts of back-to-back items separated by random gaps, sometimes none.
    task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                s_value <= $urandom;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (text.len() != 0) push_typed_text(text);
        else predict_text(v);
    endtask

    // Receiver backpressure
    always @(negedge aclk) begin
        if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_cycle <= rx_cycle + 1;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= (rx_cycle % 8 == 0);
            default:   m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Compare each character transfer with the oldest expectation
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %0d last %0b", m_char_code, m_last));
            end else begin
                want = pending_chars.pop_front();
                if (m_char_code !== want.code)
                    report_mismatch($sformatf("char_code %0d, want %0d", m_char_code, want.code));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
        end
    end

    // Main sequence
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) send_value(dir_value[i], dir_text[i]);
        for (int i = 0; i < RAND_N; i++) send_value(pick_value(), "");

        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT;
        $display("TB_ERROR");
        $finish;
    end

endmodule
